@@ src/cf_homographic_transform_unit_defines.svh @@
// Assertion macros for the homographic transform unit.
// No dependencies; included by the files that carry assertions.
`ifndef CF_HOMOGRAPHIC_TRANSFORM_UNIT_DEFINES_SVH
`define CF_HOMOGRAPHIC_TRANSFORM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define CFHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CFHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFHT_ASSERT_IMP(lbl, ante, cons, msg)
`define CFHT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/cfht_pkg.sv @@
// Shared types and constants for the homographic transform unit.
// No dependencies.
package cfht_pkg;

  // field widths fixed by the interface
  localparam int TERM_W     = 32;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_COEF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_COEF  = 2'd1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NEGN,
    ST_NEGD,
    ST_DIV,
    ST_FIX,
    ST_PUSH_TERM,
    ST_PUSH_END,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage

@@ src/cf_homographic_transform_unit.sv @@
// Top level: Gosper box transform z = a + b*x of a streamed continued fraction.
// Depends on cfht_pkg and cf_homographic_transform_unit_defines.svh.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | input     | in_valid/in_stall  | in_term, in_end_of_input
//  out_    | output    | out_valid/out_stall| out_term, out_is_end, out_last
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item at a time: a shared (WORD_BITS+1)-bit adder does shift-add multiplies
// and restoring divides, one bit per cycle. A new input word is not accepted
// until the sequencer has finished with the last one and is back in idle.
// Output stalls hold the sequencer only while a word waits to be handed on.
// Reset (synchronous) loads a=0, b=1, box (0,1,1,0); register writes reload it.
`include "cf_homographic_transform_unit_defines.svh"

module cf_homographic_transform_unit #(
  parameter int WORD_BITS = 32,
  parameter int MAX_EMIT  = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cfht_pkg::TERM_W-1:0]  in_term,
  input  logic                                in_end_of_input,
  // result words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cfht_pkg::TERM_W-1:0]  out_term,
  output logic                                out_is_end,
  output logic                                out_last,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cfht_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfht_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int W      = WORD_BITS;
  localparam int STEP_W = $clog2(WORD_BITS);
  localparam int CNT_W  = $clog2(MAX_EMIT);

  // sequencer
  cfht_pkg::state_t state_r, state_nxt;

  // coefficients and box
  logic [cfht_pkg::CFG_DATA_W-1:0] offset_r, offset_nxt;
  logic [cfht_pkg::CFG_DATA_W-1:0] scale_r, scale_nxt;
  logic [W-1:0] np_r, np_nxt, nc_r, nc_nxt, dp_r, dp_nxt, dc_r, dc_nxt;

  // arithmetic work registers
  logic [W-1:0] acc_r, acc_nxt, opa_r, opa_nxt, opb_r, opb_nxt, p_r, p_nxt;
  logic [W-1:0] rem_r, rem_nxt, dvd_r, dvd_nxt, dvs_r, dvs_nxt, q0_r, q0_nxt;
  logic         neg_r, neg_nxt;
  logic         sel_r, sel_nxt;
  logic         mul_emit_r, mul_emit_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // item control
  logic             endm_r, endm_nxt;
  logic             was_done_r, was_done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // one result held back until it is known whether it is the last
  logic                pend_valid_r, pend_valid_nxt;
  logic signed [W-1:0] pend_term_r, pend_term_nxt;
  logic                pend_end_r, pend_end_nxt;

  // output register
  logic                               out_valid_r, out_valid_nxt;
  logic signed [cfht_pkg::TERM_W-1:0] out_term_r, out_term_nxt;
  logic                               out_is_end_r, out_is_end_nxt;
  logic                               out_last_r, out_last_nxt;

  // shared adder
  logic [W:0]   alu_x, alu_y, alu_sum;
  logic         alu_sub;

  // helpers
  logic                in_acc, cfg_acc, cfg_hit, out_free, push_ok;
  logic                step_last, box_done, can_emit, tail_end, q_match;
  logic signed [W-1:0] p_ext;
  logic [W-1:0]        div_n, div_d, rem_sh, fix_q, mul_final;
  logic [cfht_pkg::CFG_DATA_W-1:0] off_new, scl_new;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign push_ok   = !pend_valid_r || out_free;
  assign step_last = (step_r == STEP_W'(W - 1));
  assign box_done  = (dp_r == '0) && (dc_r == '0);
  assign can_emit  = (cnt_r < CNT_W'(MAX_EMIT - 1));
  assign tail_end  = !was_done_r && box_done;
  assign p_ext     = W'(in_term);

  // divide operands: pair 0 is the prev column, pair 1 the curr column
  assign div_n  = sel_r ? nc_r : np_r;
  assign div_d  = sel_r ? dc_r : dp_r;
  assign rem_sh = {rem_r[W-2:0], dvd_r[W-1]};

  // operand select for the shared adder
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      cfht_pkg::ST_NEGN: begin
        alu_y   = {1'b0, div_n};
        alu_sub = 1'b1;
      end
      cfht_pkg::ST_NEGD: begin
        alu_y   = {1'b0, div_d};
        alu_sub = 1'b1;
      end
      cfht_pkg::ST_DIV: begin
        alu_x   = {1'b0, rem_sh};
        alu_y   = {1'b0, dvs_r};
        alu_sub = 1'b1;
      end
      cfht_pkg::ST_FIX: begin
        alu_y   = {1'b0, dvd_r};
        alu_sub = 1'b1;
      end
      cfht_pkg::ST_MUL: begin
        alu_x   = {1'b0, acc_r};
        alu_y   = {1'b0, opa_r};
        alu_sub = mul_emit_r;
      end
      default: begin
      end
    endcase
  end

  assign alu_sum   = alu_x + (alu_sub ? ~alu_y : alu_y) + {{W{1'b0}}, alu_sub};
  assign fix_q     = neg_r ? alu_sum[W-1:0] : dvd_r;
  assign q_match   = (fix_q == q0_r);
  assign mul_final = opb_r[0] ? alu_sum[W-1:0] : acc_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfht_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = in_end_of_input ? cfht_pkg::ST_CHECK : cfht_pkg::ST_MUL;
      end
      cfht_pkg::ST_CHECK: begin
        if (endm_r) begin
          state_nxt = (can_emit && dp_r != '0) ? cfht_pkg::ST_NEGN : cfht_pkg::ST_PUSH_END;
        end else if (can_emit && dp_r != '0 && dc_r != '0) begin
          state_nxt = cfht_pkg::ST_NEGN;
        end else begin
          state_nxt = tail_end ? cfht_pkg::ST_PUSH_END : cfht_pkg::ST_DONE;
        end
      end
      cfht_pkg::ST_NEGN: state_nxt = cfht_pkg::ST_NEGD;
      cfht_pkg::ST_NEGD: state_nxt = cfht_pkg::ST_DIV;
      cfht_pkg::ST_DIV: begin
        if (step_last) state_nxt = cfht_pkg::ST_FIX;
      end
      cfht_pkg::ST_FIX: begin
        if (!sel_r) begin
          state_nxt = endm_r ? cfht_pkg::ST_PUSH_TERM : cfht_pkg::ST_NEGN;
        end else if (q_match) begin
          state_nxt = cfht_pkg::ST_PUSH_TERM;
        end else begin
          state_nxt = tail_end ? cfht_pkg::ST_PUSH_END : cfht_pkg::ST_DONE;
        end
      end
      cfht_pkg::ST_PUSH_TERM: begin
        if (push_ok) state_nxt = cfht_pkg::ST_MUL;
      end
      cfht_pkg::ST_PUSH_END: begin
        if (push_ok) state_nxt = cfht_pkg::ST_DONE;
      end
      cfht_pkg::ST_MUL: begin
        if (step_last && sel_r) state_nxt = cfht_pkg::ST_CHECK;
      end
      cfht_pkg::ST_DONE: begin
        if (push_ok) state_nxt = cfht_pkg::ST_IDLE;
      end
      default: state_nxt = cfht_pkg::ST_IDLE;
    endcase
  end

  // new coefficient values on a register write; other indexes change nothing
  always_comb begin
    off_new = offset_r;
    scl_new = scale_r;
    cfg_hit = 1'b0;
    if (cfg_acc) begin
      unique case (cfg_index)
        cfht_pkg::REG_OFFSET_COEF: begin
          off_new = cfg_data;
          cfg_hit = 1'b1;
        end
        cfht_pkg::REG_SCALE_COEF: begin
          scl_new = cfg_data;
          cfg_hit = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath and outputs of the sequencer
  always_comb begin
    offset_nxt     = offset_r;
    scale_nxt      = scale_r;
    np_nxt         = np_r;
    nc_nxt         = nc_r;
    dp_nxt         = dp_r;
    dc_nxt         = dc_r;
    acc_nxt        = acc_r;
    opa_nxt        = opa_r;
    opb_nxt        = opb_r;
    p_nxt          = p_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    dvs_nxt        = dvs_r;
    q0_nxt         = q0_r;
    neg_nxt        = neg_r;
    sel_nxt        = sel_r;
    mul_emit_nxt   = mul_emit_r;
    step_nxt       = step_r;
    endm_nxt       = endm_r;
    was_done_nxt   = was_done_r;
    cnt_nxt        = cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_term_nxt  = pend_term_r;
    pend_end_nxt   = pend_end_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_term_nxt   = out_term_r;
    out_is_end_nxt = out_is_end_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      cfht_pkg::ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt = '0;
          if (in_end_of_input) begin
            // x goes to infinity: keep the curr column only
            np_nxt   = nc_r;
            dp_nxt   = dc_r;
            endm_nxt = 1'b1;
          end else begin
            acc_nxt      = np_r;
            opa_nxt      = nc_r;
            opb_nxt      = p_ext;
            p_nxt        = p_ext;
            sel_nxt      = 1'b0;
            mul_emit_nxt = 1'b0;
            step_nxt     = '0;
            endm_nxt     = 1'b0;
            was_done_nxt = box_done;
          end
        end else if (cfg_hit) begin
          offset_nxt = off_new;
          scale_nxt  = scl_new;
          np_nxt     = W'(off_new);
          nc_nxt     = W'(scl_new);
          dp_nxt     = W'(1);
          dc_nxt     = '0;
        end
      end
      cfht_pkg::ST_CHECK: sel_nxt = 1'b0;
      cfht_pkg::ST_NEGN: begin
        dvd_nxt = div_n[W-1] ? alu_sum[W-1:0] : div_n;
        neg_nxt = div_n[W-1] ^ div_d[W-1];
      end
      cfht_pkg::ST_NEGD: begin
        dvs_nxt  = div_d[W-1] ? alu_sum[W-1:0] : div_d;
        rem_nxt  = '0;
        step_nxt = '0;
      end
      cfht_pkg::ST_DIV: begin
        // restoring step: keep the trial difference when it does not borrow
        if (!alu_sum[W]) begin
          rem_nxt = alu_sum[W-1:0];
          dvd_nxt = {dvd_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          dvd_nxt = {dvd_r[W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
      end
      cfht_pkg::ST_FIX: begin
        if (!sel_r) begin
          q0_nxt  = fix_q;
          sel_nxt = 1'b1;
        end
      end
      cfht_pkg::ST_PUSH_TERM: begin
        if (push_ok) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_term_nxt   = cfht_pkg::TERM_W'(pend_term_r);
            out_is_end_nxt = pend_end_r;
            out_last_nxt   = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_term_nxt  = q0_r;
          pend_end_nxt   = 1'b0;
          cnt_nxt        = cnt_r + CNT_W'(1);
          // first product: num_prev - den_prev*q
          acc_nxt        = np_r;
          opa_nxt        = dp_r;
          opb_nxt        = q0_r;
          sel_nxt        = 1'b0;
          mul_emit_nxt   = 1'b1;
          step_nxt       = '0;
        end
      end
      cfht_pkg::ST_PUSH_END: begin
        if (push_ok) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_term_nxt   = cfht_pkg::TERM_W'(pend_term_r);
            out_is_end_nxt = pend_end_r;
            out_last_nxt   = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_term_nxt  = '0;
          pend_end_nxt   = 1'b1;
          if (endm_r) begin
            np_nxt   = W'(offset_r);
            nc_nxt   = W'(scale_r);
            dp_nxt   = W'(1);
            dc_nxt   = '0;
            endm_nxt = 1'b0;
          end
        end
      end
      cfht_pkg::ST_MUL: begin
        if (!step_last) begin
          acc_nxt  = mul_final;
          opa_nxt  = {opa_r[W-2:0], 1'b0};
          opb_nxt  = {1'b0, opb_r[W-1:1]};
          step_nxt = step_r + STEP_W'(1);
        end else begin
          step_nxt = '0;
          case ({mul_emit_r, sel_r})
            2'b00: begin
              // input term, numerator column done
              np_nxt  = nc_r;
              nc_nxt  = mul_final;
              acc_nxt = dp_r;
              opa_nxt = dc_r;
              opb_nxt = p_r;
              sel_nxt = 1'b1;
            end
            2'b01: begin
              dp_nxt = dc_r;
              dc_nxt = mul_final;
            end
            2'b10: begin
              // term given, prev column done
              np_nxt  = dp_r;
              dp_nxt  = mul_final;
              acc_nxt = nc_r;
              opa_nxt = dc_r;
              opb_nxt = q0_r;
              sel_nxt = 1'b1;
            end
            default: begin
              nc_nxt = dc_r;
              dc_nxt = mul_final;
            end
          endcase
        end
      end
      cfht_pkg::ST_DONE: begin
        // hand on the held result marked as the last of this item
        if (pend_valid_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_term_nxt   = cfht_pkg::TERM_W'(pend_term_r);
          out_is_end_nxt = pend_end_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // control state and box
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cfht_pkg::ST_IDLE;
      offset_r     <= '0;
      scale_r      <= cfht_pkg::CFG_DATA_W'(1);
      np_r         <= '0;
      nc_r         <= W'(1);
      dp_r         <= W'(1);
      dc_r         <= '0;
      sel_r        <= 1'b0;
      mul_emit_r   <= 1'b0;
      step_r       <= '0;
      endm_r       <= 1'b0;
      was_done_r   <= 1'b0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      offset_r     <= offset_nxt;
      scale_r      <= scale_nxt;
      np_r         <= np_nxt;
      nc_r         <= nc_nxt;
      dp_r         <= dp_nxt;
      dc_r         <= dc_nxt;
      sel_r        <= sel_nxt;
      mul_emit_r   <= mul_emit_nxt;
      step_r       <= step_nxt;
      endm_r       <= endm_nxt;
      was_done_r   <= was_done_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    opa_r        <= opa_nxt;
    opb_r        <= opb_nxt;
    p_r          <= p_nxt;
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    dvs_r        <= dvs_nxt;
    q0_r         <= q0_nxt;
    neg_r        <= neg_nxt;
    pend_term_r  <= pend_term_nxt;
    pend_end_r   <= pend_end_nxt;
    out_term_r   <= out_term_nxt;
    out_is_end_r <= out_is_end_nxt;
    out_last_r   <= out_last_nxt;
  end

  // ports; a register write waits while an input word is offered
  assign in_stall   = (state_r != cfht_pkg::ST_IDLE);
  assign cfg_ready  = (state_r == cfht_pkg::ST_IDLE) && !in_valid;
  assign out_valid  = out_valid_r;
  assign out_term   = out_term_r;
  assign out_is_end = out_is_end_r;
  assign out_last   = out_last_r;

  // checks
  `CFHT_ASSERT_IMP(a_idle_no_pend, state_r == cfht_pkg::ST_IDLE, !pend_valid_r,
    "held result left over at end of item")
  `CFHT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_EMIT - 1),
    "term count beyond limit")
  `CFHT_ASSERT_IMP(a_div_nonzero, state_r == cfht_pkg::ST_DIV, dvs_r != '0,
    "divide by zero in shared unit")
  `CFHT_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, state_r != cfht_pkg::ST_IDLE,
    "sequencer idle after accepting a word")
  `CFHT_ASSERT_IMP(a_end_zero, out_valid_r && out_is_end_r, out_term_r == '0,
    "end marker with nonzero term")

endmodule
